// ===== hdl/ccl_pkg.sv =====
// shared types and constants for the collatz chain length block
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ccl_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [15:0] STEP_LIMIT_RESET   = 16'd1000;
    localparam logic [31:0] RECORD_START_RESET = 32'd1;
    localparam logic [15:0] RECORD_LEN_RESET   = 16'd0;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO     = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_LIMIT    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ccl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic out_free;
    } ccl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ccl_ctrl.sv =====
// sequencer for the collatz chain length block: load, iterate, finish
// depends on ccl_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module ccl_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ccl_pkg::ccl_stat_t stat,
    output ccl_pkg::ccl_cmd_t      cmd
);
    import ccl_pkg::*;

    typedef enum logic {
        IDLE,
        RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = RUN;
                end
            end
            RUN:
            begin
                if (!stat.done)
                begin
                    cmd.step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    // finish once the output slot is free; until then hold here with the chain frozen
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ccl_datapath.sv =====
// datapath: collatz step unit, step counter, record registers and output stage
// depends on ccl_pkg for status codes, reset constants and the control structs
`timescale 1ns / 1ps
`default_nettype none

module ccl_datapath
#(
    parameter int VALUE_WIDTH = ccl_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = ccl_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [15:0]       step_limit,
    input  wire logic [31:0]       start_value,
    input  wire logic              restart,
    input  wire ccl_pkg::ccl_cmd_t cmd,
    output ccl_pkg::ccl_stat_t     stat,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [15:0]            chain_length,
    output logic [31:0]            best_start,
    output logic [15:0]            best_length,
    output logic [1:0]             status
);
    import ccl_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
    // largest value whose 3n+1 still fits
    localparam logic [VALUE_WIDTH-1:0] OVF_LIMIT = VALUE_WIDTH'((VALUE_MAX - 1'b1) / 3);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [VALUE_WIDTH-1:0] TARGET    = VALUE_WIDTH'(4);

    logic [15:0]            step_limit_reg;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [COUNT_WIDTH-1:0] steps_reg, steps_next;
    logic [COUNT_WIDTH-1:0] limit_reg, limit_next;
    logic [31:0]            start_reg, start_next;
    logic [31:0]            record_start_reg, record_start_next;
    logic [15:0]            record_length_reg, record_length_next;
    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            chain_length_reg;
    logic [31:0]            best_start_reg;
    logic [15:0]            best_length_reg;
    status_t                status_reg;

    logic                   done;
    status_t                term_status;
    logic [VALUE_WIDTH-1:0] value_stepped;
    logic [VALUE_WIDTH-1:0] start_cut;
    logic                   record_take;

    // termination check, in the priority order of the chain rules
    always_comb
    begin
        done        = 1'b1;
        term_status = STATUS_OK;
        if (value_reg == '0)
        begin
            term_status = STATUS_ZERO;
        end
        else if (value_reg == TARGET)
        begin
            term_status = STATUS_OK;
        end
        else if (steps_reg >= limit_reg)
        begin
            term_status = STATUS_LIMIT;
        end
        else if (value_reg[0] && (value_reg > OVF_LIMIT))
        begin
            term_status = STATUS_OVERFLOW;
        end
        else
        begin
            done = 1'b0;
        end
    end

    // 3n+1 as 2n+n+1, or a halving
    assign value_stepped = value_reg[0]
        ? ({value_reg[VALUE_WIDTH-2:0], 1'b0} + value_reg + VALUE_WIDTH'(1))
        : (value_reg >> 1);

    assign start_cut   = VALUE_WIDTH'(start_value);
    assign record_take = (term_status == STATUS_OK) && (32'(steps_reg) > 32'(record_length_reg));

    always_comb
    begin
        value_next         = value_reg;
        steps_next         = steps_reg;
        limit_next         = limit_reg;
        start_next         = start_reg;
        record_start_next  = record_start_reg;
        record_length_next = record_length_reg;
        if (cmd.load)
        begin
            value_next = start_cut;
            start_next = 32'(start_cut);
            steps_next = '0;
            limit_next = (32'(step_limit_reg) > 32'(COUNT_MAX))
                       ? COUNT_MAX : COUNT_WIDTH'(step_limit_reg);
            if (restart)
            begin
                record_start_next  = RECORD_START_RESET;
                record_length_next = RECORD_LEN_RESET;
            end
        end
        else if (cmd.step)
        begin
            value_next = value_stepped;
            steps_next = steps_reg + COUNT_WIDTH'(1);
        end
        else if (cmd.finish && record_take)
        begin
            record_start_next  = start_reg;
            record_length_next = 16'(steps_reg);
        end
    end

    assign out_valid_next = cmd.finish | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg    <= STEP_LIMIT_RESET;
            record_start_reg  <= RECORD_START_RESET;
            record_length_reg <= RECORD_LEN_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                step_limit_reg <= step_limit;
            end
            record_start_reg  <= record_start_next;
            record_length_reg <= record_length_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        steps_reg <= steps_next;
        limit_reg <= limit_next;
        start_reg <= start_next;
        if (cmd.finish)
        begin
            chain_length_reg <= 16'(steps_reg);
            best_start_reg   <= record_start_next;
            best_length_reg  <= record_length_next;
            status_reg       <= term_status;
        end
    end

    assign stat.done     = done;
    assign stat.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid    = out_valid_reg;
    assign chain_length = chain_length_reg;
    assign best_start   = best_start_reg;
    assign best_length  = best_length_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ===== hdl/collatz_chain_length_max_core.sv =====
// an accepted item is loaded, takes one collatz step per cycle until a stop rule ends the chain,
// then is finished into the output register; no new item is taken before that finish, but
// the output register lets the next item start while a result waits
// reset: asynchronous active low; step_limit returns to 1000, record to start 1, length 0
// top level of the collatz chain length block; depends on ccl_pkg, ccl_ctrl, ccl_datapath
`timescale 1ns / 1ps
`default_nettype none

module collatz_chain_length_max_core
#(
    parameter int VALUE_WIDTH = ccl_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = ccl_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] step_limit,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] start_value,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      chain_length,
    output logic [31:0]      best_start,
    output logic [15:0]      best_length,
    output logic [1:0]       status
);
    import ccl_pkg::*;

    ccl_cmd_t  cmd;
    ccl_stat_t stat;

    assign cfg_ready = 1'b1;

    ccl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ccl_datapath
    #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid & cfg_ready),
        .step_limit   (step_limit),
        .start_value  (start_value),
        .restart      (restart),
        .cmd          (cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .chain_length (chain_length),
        .best_start   (best_start),
        .best_length  (best_length),
        .status       (status)
    );

    // an accepted item closes the input side in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a chain is running");

    // a new result only appears when the sequencer has just gone idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while the controller is busy");

    // a zero start never takes a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_ZERO)) |-> (chain_length == 16'd0))
        else $error("zero start reported nonzero chain length");

    // commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for collatz_chain_length_max_core: drives start values, predicts chain length,
// record and status per item in a small tracker class, and checks every result in order
// depends on ccl_pkg and the collatz_chain_length_max_core rtl
`timescale 1ns / 1ps

module tb;

    import ccl_pkg::*;

    localparam logic [63:0] VALUE_MAX      = (64'd1 << VALUE_WIDTH_DEF) - 64'd1;
    localparam int unsigned COUNT_MAX      = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int          LONG_HOLD      = 500;
    localparam int          WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [15:0] chain_length;
        logic [31:0] best_start;
        logic [15:0] best_length;
        status_t     status;
    } chain_result_t;

    class collatz_tracker;
        logic [15:0]   limit_reg;
        logic [31:0]   record_start;
        logic [15:0]   record_length;
        chain_result_t pending[$];
        int unsigned   mismatches;

        function new();
            limit_reg     = STEP_LIMIT_RESET;
            record_start  = RECORD_START_RESET;
            record_length = RECORD_LEN_RESET;
            mismatches    = 0;
        endfunction

        // walk the chain of one accepted item and queue what it must produce
        function void note_start(logic [31:0] origin, logic clear_record);
            logic [63:0]   n;
            int unsigned   limit;
            int unsigned   steps;
            status_t       st;
            chain_result_t r;
            n     = {32'd0, origin} & VALUE_MAX;
            limit = limit_reg;
            steps = 0;
            st    = STATUS_OK;
            if (limit > COUNT_MAX)
                limit = COUNT_MAX;
            if (clear_record)
            begin
                record_start  = RECORD_START_RESET;
                record_length = RECORD_LEN_RESET;
            end
            if (n == 64'd0)
                st = STATUS_ZERO;
            else
            begin
                while (n != 64'd4)
                begin
                    if (steps >= limit)
                    begin
                        st = STATUS_LIMIT;
                        break;
                    end
                    if (n[0] == 1'b0)
                        n = n >> 1;
                    else if (n > (VALUE_MAX - 64'd1) / 64'd3)
                    begin
                        st = STATUS_OVERFLOW;
                        break;
                    end
                    else
                        n = n * 64'd3 + 64'd1;
                    steps++;
                end
            end
            // only a clean chain that is strictly longer takes the record
            if (st == STATUS_OK && steps > record_length)
            begin
                record_start  = origin;
                record_length = steps[15:0];
            end
            r.chain_length = steps[15:0];
            r.best_start   = record_start;
            r.best_length  = record_length;
            r.status       = st;
            pending.push_back(r);
        endfunction

        function void field_check(string label, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [15:0] len, logic [31:0] bs, logic [15:0] bl,
                                   logic [1:0] st);
            chain_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected, chain_length %0d", $time, len);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            field_check("chain_length", want.chain_length, len);
            field_check("best_start", want.best_start, bs);
            field_check("best_length", want.best_length, bl);
            field_check("status", want.status, st);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] step_limit;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] start_value;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] chain_length;
    logic [31:0] best_start;
    logic [15:0] best_length;
    logic [1:0]  status;

    collatz_tracker tracker;
    bit             calm;
    bit             hold_output;
    int             idle_cycles = 0;

    collatz_chain_length_max_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .step_limit   (step_limit),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_value  (start_value),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chain_length (chain_length),
        .best_start   (best_start),
        .best_length  (best_length),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one item, note it when taken, then maybe leave a gap
    task automatic offer_start(input logic [31:0] origin, input logic clear_record);
        in_valid    <= 1'b1;
        start_value <= origin;
        restart     <= clear_record;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_start(origin, clear_record);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // the limit only changes once every queued result is out
    task automatic write_step_limit(input logic [15:0] limit);
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        cfg_valid  <= 1'b1;
        step_limit <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.limit_reg = limit;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] limit, input int count, input bit quiet,
                             input bit hold);
        logic [31:0] origin;
        write_step_limit(limit);
        calm        = quiet;
        hold_output = hold;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0:             origin = 32'd0;
                1, 2:          origin = 32'd1 << $urandom_range(0, 31);
                3, 4:          origin = 32'd1431655700 + $urandom_range(0, 130);
                5, 6, 7, 8, 9: origin = $urandom;
                10, 11, 12:    origin = $urandom_range(1, 1 << 20);
                default:       origin = $urandom_range(1, 1000);
            endcase
            offer_start(origin, $urandom_range(0, 24) == 0);
        end
    endtask

    // receiver: short random stalls, and one long hold when asked
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(chain_length, best_start, best_length, status);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        step_limit  = 16'd0;
        in_valid    = 1'b0;
        start_value = 32'd0;
        restart     = 1'b0;
        calm        = 1'b0;
        hold_output = 1'b0;
        tracker     = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: short chains, ties, overflow edges, record clears
        offer_start(32'd0, 1'b0);
        offer_start(32'd4, 1'b0);
        offer_start(32'd1, 1'b0);
        offer_start(32'd2, 1'b0);
        offer_start(32'd3, 1'b1);
        offer_start(32'd20, 1'b0);
        offer_start(32'd6, 1'b0);
        offer_start(32'd27, 1'b0);
        offer_start(32'd0, 1'b1);
        offer_start(32'd837799, 1'b0);
        offer_start(32'h8000_0000, 1'b0);
        offer_start(32'hFFFF_FFFF, 1'b0);
        offer_start(32'hFFFF_FFFE, 1'b0);
        offer_start(32'd1431655764, 1'b0);
        offer_start(32'd1431655765, 1'b0);
        offer_start(32'd1431655763, 1'b0);
        offer_start(32'd63728127, 1'b0);
        offer_start(32'hAAAA_AAAA, 1'b0);
        offer_start(32'd7, 1'b1);

        // zero limit flags everything but a start of 4
        write_step_limit(16'd0);
        offer_start(32'd4, 1'b0);
        offer_start(32'd9, 1'b0);
        offer_start(32'd0, 1'b0);
        offer_start(32'd1, 1'b1);

        run_phase(16'hFFFF, 120, 1'b0, 1'b0);
        run_phase(16'd1, 60, 1'b0, 1'b0);
        run_phase(16'($urandom_range(2, 200)), 120, 1'b0, 1'b1);
        run_phase(16'($urandom_range(200, 2000)), 120, 1'b0, 1'b0);
        run_phase(STEP_LIMIT_RESET, 130, 1'b1, 1'b0);

        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ccl_pkg.sv
hdl/ccl_ctrl.sv
hdl/ccl_datapath.sv
hdl/collatz_chain_length_max_core.sv
dv/tb.sv
